FILE: design/sqe_pkg.sv
`timescale 1ns / 1ps

package sqe_pkg;

    // Default number of ring entries.
    localparam int DEFAULT_STORE_DEPTH = 32;

    // Operation codes.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_PRINT = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_SWAP  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One request item.
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] push_value;
    } request_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] element_value;
        logic               has_element;
        logic [1:0]         status;
        logic               last_result;
    } result_t;

endpackage

FILE: design/stack_queue_engine_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+---------------------
// request   | in        | request_valid / request_stall | sqe_pkg::request_t
// result    | out       | result_valid / result_stall   | sqe_pkg::result_t
// cfg       | in        | cfg_write_enable              | cfg_write_data
//
// Push, pop and invalid operations pass through the transfer, then the execute
// state that updates the ring and loads the result register. Peek adds the
// element state; swap adds the hold state and the write-back states, as it reads
// both entries and writes them back one access per cycle. Print-all streams one
// element per cycle from the registered read. A stalled result holds the sequencer.
// Reset clears the front index, the count, the mode and all control state.
module stack_queue_engine_core #(
    parameter int STORE_DEPTH = sqe_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_stall,
    input  sqe_pkg::request_t request,
    output logic              result_valid,
    input  logic              result_stall,
    output sqe_pkg::result_t  result,
    input  logic              cfg_write_enable,
    input  logic              cfg_write_data
);

    import sqe_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(STORE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_ELEM    = 6'b000100,
        S_SWAP_B  = 6'b001000,
        S_SWAP_WA = 6'b010000,
        S_SWAP_WB = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg;
    logic signed [31:0]  value_reg;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                peek_reg, peek_next;
    logic                mode_reg;
    logic signed [31:0]  tmp_reg;
    logic                tmp_load;
    logic signed [31:0]  rd_data_reg;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;
    logic                emit;
    logic                out_free;
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic signed [31:0]  mem_wdata;
    logic [IDX_W-1:0]    next_idx;
    logic                elem_last;

    logic signed [31:0]  store_mem [STORE_DEPTH];

    // Ring position of an offset from the front; both operands lie below the depth.
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                  input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, offset};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free      = !result_valid_reg || !result_stall;
    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    assign next_idx  = idx_reg + 1'b1;
    assign elem_last = peek_reg ||
                       ((IDX_W + 1)'(idx_reg) + 1'b1 == (IDX_W + 1)'(count_reg));

    // Sequencer: ring pointer updates, memory accesses and result loading.
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        peek_next   = peek_reg;
        tmp_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = front_reg;
        mem_wdata   = value_reg;
        mem_re      = 1'b0;
        mem_raddr   = front_reg;
        emit        = 1'b0;
        result_next = '{element_value: '0, has_element: 1'b0,
                        status: ST_OK, last_result: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            emit = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (mode_reg)
                                begin
                                    mem_waddr = ring_pos(front_reg, count_reg[IDX_W-1:0]);
                                end
                                else
                                begin
                                    front_next = (front_reg == '0) ? LAST_INDEX
                                                                   : front_reg - 1'b1;
                                    mem_waddr  = front_next;
                                end
                            end
                        end

                        OP_PRINT, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                                if (op_reg == OP_PEEK)
                                begin
                                    result_next.status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                idx_next   = '0;
                                peek_next  = (op_reg == OP_PEEK);
                                state_next = S_ELEM;
                            end
                        end

                        OP_POP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_pos(front_reg, IDX_W'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end

                        OP_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                emit = 1'b1;
                                result_next.status = ST_SHORT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_SWAP_B;
                            end
                        end

                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            // Stream elements from the read register, one per transfer.
            S_ELEM:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    result_next.element_value = rd_data_reg;
                    result_next.has_element   = 1'b1;
                    result_next.last_result   = elem_last;
                    if (elem_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ring_pos(front_reg, next_idx);
                        idx_next  = next_idx;
                    end
                end
            end

            // Hold the front element, read the second one.
            S_SWAP_B:
            begin
                tmp_load   = 1'b1;
                mem_re     = 1'b1;
                mem_raddr  = ring_pos(front_reg, IDX_W'(1));
                state_next = S_SWAP_WA;
            end

            // Second element goes to the front position.
            S_SWAP_WA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = front_reg;
                mem_wdata  = rd_data_reg;
                state_next = S_SWAP_WB;
            end

            // Former front element goes to the second position.
            S_SWAP_WB:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ring_pos(front_reg, IDX_W'(1));
                    mem_wdata  = tmp_reg;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register valid: loaded on emit, cleared after its transfer.
    always_comb
    begin
        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            front_reg        <= '0;
            count_reg        <= '0;
            mode_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            idx_reg          <= '0;
            peek_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            idx_reg          <= idx_next;
            peek_reg         <= peek_next;
            if (cfg_write_enable)
            begin
                mode_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && request_valid)
        begin
            op_reg    <= request.operation;
            value_reg <= request.push_value;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
        if (tmp_load)
        begin
            tmp_reg <= rd_data_reg;
        end
    end

    // Ring memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    // The count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count exceeds store depth");

    // The front index stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_reg} < DEPTH_EXT)
        else $error("front index outside ring");

    // A result that carries an element always reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.has_element |-> result_reg.status == ST_OK)
        else $error("element result with error status");

    // An accepted request is always decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

    // The final element of a listing returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ELEM && out_free && elem_last |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after last element");

endmodule
